FILE: src/mwtp_pkg.sv
// ----------------------------------------------------------------------------
// mwtp_pkg
// Shared types, constants and the 2^(k/256) fraction table for the
// two-action multiplicative-weights policy table.
// ----------------------------------------------------------------------------
package mwtp_pkg;

  localparam int SUM_W    = 28;
  localparam int CNT_W    = 12;
  localparam int PER_W    = 24;
  localparam int PROB_W   = 16;
  localparam int TOTAL_W  = 40;
  localparam int DIV_W    = 50;

  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_REWARD = 2'd1;
  localparam logic [1:0] MODE_RELOAD = 2'd2;

  localparam logic [1:0] REG_EXPONENT_RATE = 2'd0;
  localparam logic [1:0] REG_UPDATE_PERIOD = 2'd1;
  localparam logic [1:0] REG_INIT_PROB     = 2'd2;

  localparam logic [15:0] RATE_RESET   = 16'd4096;
  localparam logic [11:0] PERIOD_RESET = 12'd100;
  localparam logic [15:0] PROB_RESET   = 16'd32768;

  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
  localparam logic [PER_W-1:0]   PER_MAX   = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_a;
    logic signed [SUM_W-1:0] sum_f;
    logic [CNT_W-1:0]        cnt_a;
    logic [CNT_W-1:0]        cnt_f;
    logic [CNT_W-1:0]        phase;
    logic [PER_W-1:0]        periods;
    logic [PROB_W-1:0]       prob;
    logic [TOTAL_W-1:0]      total;
  } entry_t;

  typedef logic [15:0] frac_tab_t [256];

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bv;
    x   = v;
    res = '0;
    bv  = 64'h1 << 62;
    while (bv > x) bv = bv >> 2;
    while (bv != 64'd0) begin
      if (x >= res + bv) begin
        x   = x - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  // 2^(k/256) in Q1.16, integer one implied
  function automatic frac_tab_t build_frac_tab();
    frac_tab_t   tab;
    logic [63:0] roots [9];
    logic [63:0] acc;
    roots[0] = 64'h1 << 31;
    for (int j = 1; j <= 8; j++) roots[j] = isqrt64(roots[j-1] << 30);
    for (int k = 0; k < 256; k++) begin
      acc = 64'h1 << 30;
      for (int j = 1; j <= 8; j++) begin
        if (((k >> (8 - j)) & 1) != 0) acc = (acc * roots[j] + (64'h1 << 29)) >> 30;
      end
      acc    = (acc + (64'h1 << 13)) >> 14;
      tab[k] = acc[15:0];
    end
    return tab;
  endfunction

  localparam frac_tab_t FRAC_TAB = build_frac_tab();

endpackage

FILE: src/mwtp_if.sv
// ----------------------------------------------------------------------------
// mwtp item / result channels
// Valid/ready channels carrying one request item and one result item.
// ----------------------------------------------------------------------------
interface mwtp_item_if import mwtp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [10:0]        entry;
  logic [15:0]        random;
  logic               taken_action;
  logic signed [15:0] reward;

  modport source(output valid, mode, entry, random, taken_action, reward, input ready);
  modport sink(input valid, mode, entry, random, taken_action, reward, output ready);
endinterface

interface mwtp_result_if import mwtp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               chosen_action;
  logic [PROB_W-1:0]  prob_allin;
  logic [TOTAL_W-1:0] prob_sum_allin;
  logic [PER_W-1:0]   rounds;

  modport source(output valid, chosen_action, prob_allin, prob_sum_allin, rounds,
                 input ready);
  modport sink(input valid, chosen_action, prob_allin, prob_sum_allin, rounds,
               output ready);
endinterface

FILE: src/mwtp_ram.sv
// ----------------------------------------------------------------------------
// mwtp_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module mwtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

FILE: src/mwtp_div.sv
// ----------------------------------------------------------------------------
// mwtp_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mwtp_div import mwtp_pkg::*; #(
  parameter int W = 50
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] quo
);
  localparam int CW = $clog2(W + 1);

  logic [W:0]    rem;
  logic [W-1:0]  dsr;
  logic [CW-1:0] cnt;
  logic [W:0]    rem_sh;
  logic [W:0]    trial;

  assign rem_sh = {rem[W-1:0], quo[W-1]};
  assign trial  = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dsr  <= den;
        quo  <= num;
      end else if (busy) begin
        if (!trial[W]) begin
          rem <= trial;
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[W-2:0], 1'b0};
        end
        cnt <= cnt + CW'(1);
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: src/mwu_two_action_policy_table_core.sv
// ----------------------------------------------------------------------------
// mwu_two_action_policy_table_core
// Per-entry two-action multiplicative-weights table: sample, reward, reload.
// ----------------------------------------------------------------------------
// channel   dir  fields
// item      in   mode, entry, random, taken_action, reward
// result    out  chosen_action, prob_allin, prob_sum_allin, rounds
// cfg       in   cfg_we, cfg_idx, cfg_data (exponent_rate, update_period, init_prob)
//
// Sample, reload and non-closing reward items pass through table read,
// update and write-back; an out-of-range item skips the read. A reward that
// closes a period runs three passes of the shared bit-serial divider plus the
// arithmetic steps S_MUL, S_EXP, S_TMUL and S_DEN. After reset a clearing
// pass writes every entry, one per cycle, while item.ready stays low. A
// stalled result holds the write-back state until the result is taken.
// ----------------------------------------------------------------------------
module mwu_two_action_policy_table_core import mwtp_pkg::*; #(
  parameter int HAND_CLASSES = 169,
  parameter int SITUATIONS   = 8
) (
  input  logic               clk,
  input  logic               rst,
  mwtp_item_if.sink          item,
  mwtp_result_if.source      result,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [15:0]        cfg_data
);
  localparam int DEPTH = SITUATIONS * HAND_CLASSES;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = $bits(entry_t);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_DIVA, S_DIVF, S_MUL, S_EXP, S_TMUL, S_DEN, S_DIVP, S_WB
  } state_t;

  state_t state;

  logic [15:0] exponent_rate;
  logic [11:0] update_period;
  logic [15:0] init_prob;

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent_rate <= RATE_RESET;
      update_period <= PERIOD_RESET;
      init_prob     <= PROB_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_EXPONENT_RATE: exponent_rate <= cfg_data;
        REG_UPDATE_PERIOD: update_period <= cfg_data[11:0];
        REG_INIT_PROB:     init_prob     <= cfg_data;
        default: ;
      endcase
    end
  end

  // table memory
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic          mem_re;
  logic [EW-1:0] mem_rdata;
  entry_t        cur;
  entry_t        ent;
  entry_t        init_ent;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] addr_q;
  logic          accept;
  logic          in_range;

  assign init_ent  = '{sum_a: '0, sum_f: '0, cnt_a: '0, cnt_f: '0, phase: '0,
                       periods: '0, prob: PROB_RESET, total: TOTAL_W'(PROB_RESET)};
  assign accept    = item.valid && item.ready;
  assign in_range  = 32'(item.entry) < DEPTH;
  assign mem_re    = accept && in_range;
  assign cur       = entry_t'(mem_rdata);

  logic oor;
  assign mem_we    = (state == S_CLEAR) || (state == S_WB && !oor);
  assign mem_waddr = (state == S_CLEAR) ? clr_addr : addr_q;
  assign mem_wdata = (state == S_CLEAR) ? EW'(init_ent) : EW'(ent);

  mwtp_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(AW'(item.entry)),
    .rdata(mem_rdata)
  );

  // shared divider
  logic             div_start;
  logic [DIV_W-1:0] div_num;
  logic [DIV_W-1:0] div_den;
  logic             div_busy;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;

  mwtp_div #(.W(DIV_W)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .done (div_done),
    .quo  (div_quo)
  );

  // item fields
  logic [1:0]         mode_q;
  logic [15:0]        random_q;
  logic               act_q;
  logic signed [15:0] reward_q;
  logic               chosen_q;

  // update of the fetched entry
  entry_t             upd;
  logic               period_end;
  logic               chosen_c;
  logic signed [28:0] add_c;
  logic [11:0]        per_c;

  always_comb begin
    upd        = cur;
    period_end = 1'b0;
    chosen_c   = 1'b0;
    add_c      = '0;
    per_c      = (update_period == 12'd0) ? 12'd1 : update_period;
    unique case (mode_q)
      MODE_SAMPLE: chosen_c = random_q < cur.prob;
      MODE_REWARD: begin
        if (act_q) begin
          add_c = {cur.sum_a[SUM_W-1], cur.sum_a} + 29'(reward_q);
          if (cur.cnt_a != CNT_MAX) upd.cnt_a = cur.cnt_a + CNT_W'(1);
        end else begin
          add_c = {cur.sum_f[SUM_W-1], cur.sum_f} + 29'(reward_q);
          if (cur.cnt_f != CNT_MAX) upd.cnt_f = cur.cnt_f + CNT_W'(1);
        end
        // saturate on overflow of the 28-bit sum
        if (add_c[28] != add_c[27]) add_c = add_c[28] ? 29'(-(29'sd1 <<< 27))
                                                     : 29'((29'sd1 <<< 27) - 29'sd1);
        if (act_q) upd.sum_a = add_c[27:0];
        else       upd.sum_f = add_c[27:0];
        if ({1'b0, cur.phase} + 13'd1 >= {1'b0, per_c}) begin
          upd.phase  = '0;
          period_end = 1'b1;
        end else begin
          upd.phase = cur.phase + CNT_W'(1);
        end
      end
      MODE_RELOAD: begin
        upd       = init_ent;
        upd.prob  = (init_prob == 16'd0) ? 16'd1 : init_prob;
        upd.total = TOTAL_W'(upd.prob);
      end
      default: ;
    endcase
  end

  // period-end arithmetic
  logic signed [SUM_W-1:0] avg_a;
  logic signed [SUM_W-1:0] avg_f;
  logic signed [45:0]      prod;
  logic signed [4:0]       ip_q;
  logic [16:0]             fr_q;
  logic [16:0]             qp_q;
  logic [33:0]             t0;

  logic [SUM_W-1:0]        mag_a;
  logic [SUM_W-1:0]        mag_f;
  logic [SUM_W-1:0]        mag_upd_a;
  logic signed [SUM_W:0]   diff_c;
  logic signed [45:0]      dfl_c;
  logic signed [12:0]      d_c;
  logic [48:0]             t_c;
  logic [DIV_W-1:0]        den_c;
  logic [DIV_W-1:0]        num_c;
  logic [15:0]             pn_c;
  logic [TOTAL_W:0]        tot_c;
  logic [SUM_W-1:0]        q_trunc;

  assign mag_upd_a = upd.sum_a[SUM_W-1] ? SUM_W'(-upd.sum_a) : upd.sum_a;
  assign mag_a     = ent.sum_a[SUM_W-1] ? SUM_W'(-ent.sum_a) : ent.sum_a;
  assign mag_f     = ent.sum_f[SUM_W-1] ? SUM_W'(-ent.sum_f) : ent.sum_f;
  assign q_trunc   = div_quo[SUM_W-1:0];
  assign diff_c    = {avg_f[SUM_W-1], avg_f} - {avg_a[SUM_W-1], avg_a};
  assign dfl_c     = (prod + 46'sd2048) >>> 12;

  always_comb begin
    if (dfl_c < -46'sd4096)     d_c = -13'sd4096;
    else if (dfl_c > 46'sd4095) d_c = 13'sd4095;
    else                        d_c = dfl_c[12:0];
  end

  assign t_c   = ip_q[4] ? (49'(t0) >> 5'(-ip_q)) : (49'(t0) << ip_q[3:0]);
  assign den_c = (DIV_W'(ent.prob) << 16) + DIV_W'(t_c);
  assign num_c = (DIV_W'(ent.prob) << 32) + (den_c >> 1);

  always_comb begin
    if (div_quo > DIV_W'(16'hFFFF)) pn_c = 16'hFFFF;
    else if (div_quo == '0)         pn_c = 16'd1;
    else                            pn_c = div_quo[15:0];
  end
  assign tot_c = {1'b0, ent.total} + (TOTAL_W + 1)'(pn_c);

  // result register
  logic               res_valid;
  logic               res_chosen;
  logic [PROB_W-1:0]  res_prob;
  logic [TOTAL_W-1:0] res_total;
  logic [PER_W-1:0]   res_rounds;
  logic               res_free;

  assign res_free              = !res_valid || result.ready;
  assign result.valid          = res_valid;
  assign result.chosen_action  = res_chosen;
  assign result.prob_allin     = res_prob;
  assign result.prob_sum_allin = res_total;
  assign result.rounds         = res_rounds;
  assign item.ready            = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      res_valid <= 1'b0;
      div_start <= 1'b0;
      oor       <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (res_valid && result.ready) res_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (32'(clr_addr) == DEPTH - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            mode_q   <= item.mode;
            random_q <= item.random;
            act_q    <= item.taken_action;
            reward_q <= item.reward;
            addr_q   <= AW'(item.entry);
            oor      <= !in_range;
            state    <= in_range ? S_RD : S_WB;
          end
        end
        S_RD: begin
          ent      <= upd;
          chosen_q <= chosen_c;
          if (period_end) begin
            div_start <= 1'b1;
            div_num   <= DIV_W'(mag_upd_a);
            div_den   <= DIV_W'((upd.cnt_a == '0) ? CNT_W'(1) : upd.cnt_a);
            state     <= S_DIVA;
          end else begin
            state <= S_WB;
          end
        end
        S_DIVA: begin
          if (div_done) begin
            avg_a     <= ent.sum_a[SUM_W-1] ? SUM_W'(-q_trunc) : q_trunc;
            div_start <= 1'b1;
            div_num   <= DIV_W'(mag_f);
            div_den   <= DIV_W'((ent.cnt_f == '0) ? CNT_W'(1) : ent.cnt_f);
            state     <= S_DIVF;
          end
        end
        S_DIVF: begin
          if (div_done) begin
            avg_f <= ent.sum_f[SUM_W-1] ? SUM_W'(-q_trunc) : q_trunc;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= 46'($signed({1'b0, exponent_rate}) * diff_c);
          state <= S_EXP;
        end
        S_EXP: begin
          ip_q  <= d_c[12:8];
          fr_q  <= 17'h10000 + 17'(FRAC_TAB[d_c[7:0]]);
          qp_q  <= 17'h10000 - 17'(ent.prob);
          state <= S_TMUL;
        end
        S_TMUL: begin
          t0    <= fr_q * qp_q;
          state <= S_DEN;
        end
        S_DEN: begin
          div_start <= 1'b1;
          div_num   <= num_c;
          div_den   <= den_c;
          state     <= S_DIVP;
        end
        S_DIVP: begin
          if (div_done) begin
            ent.prob  <= pn_c;
            ent.total <= tot_c[TOTAL_W] ? TOTAL_MAX : tot_c[TOTAL_W-1:0];
            if (ent.periods != PER_MAX) ent.periods <= ent.periods + PER_W'(1);
            ent.sum_a <= '0;
            ent.sum_f <= '0;
            ent.cnt_a <= '0;
            ent.cnt_f <= '0;
            state     <= S_WB;
          end
        end
        S_WB: begin
          if (res_free) begin
            res_valid <= 1'b1;
            if (oor) begin
              res_chosen <= 1'b0;
              res_prob   <= '0;
              res_total  <= '0;
              res_rounds <= '0;
            end else begin
              res_chosen <= chosen_q;
              res_prob   <= ent.prob;
              res_total  <= ent.total;
              res_rounds <= (ent.periods != PER_MAX) ? ent.periods + PER_W'(1) : PER_MAX;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // no item is taken during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !item.ready)
    else $error("item taken during clearing pass");

  // divider is never restarted while working
  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // a new result only appears right after write-back
  a_result_from_wb: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !$past(res_valid)) |-> $past(state == S_WB))
    else $error("result without write-back");

  // the table is not written while an item is being fetched
  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    mem_re |-> !mem_we)
    else $error("table write collides with fetch");
endmodule
